// ----- design/pps_pkg.sv -----
// ============================================================================
// pps_pkg: shared types and constants of the preemptive priority scheduler
// Table geometry, request kinds, table entry and compare status types.
// ============================================================================
package pps_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] arrival_time;
        logic [15:0] remaining;
        logic [7:0]  priority_level;
    } entry_t;

    typedef struct packed {
        logic has_work;   // valid and remaining work nonzero
        logic eligible;   // has work and has arrived
        logic take;       // eligible and wins over the current best
    } cmp_res_t;

endpackage

// ----- design/pps_cmd_if.sv -----
// ============================================================================
// pps_cmd_if: request channel of the scheduler
// Valid/ready channel that carries one clear, load or tick request.
// ============================================================================
interface pps_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] task_id;
    logic [15:0] arrival_time;
    logic [15:0] run_time;
    logic [7:0]  priority_level;

    modport source (
        output valid, kind, slot, task_id, arrival_time, run_time, priority_level,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, task_id, arrival_time, run_time, priority_level,
        output ready
    );
endinterface

// ----- design/pps_rsp_if.sv -----
// ============================================================================
// pps_rsp_if: result channel of the scheduler
// Valid/ready channel that carries the outcome of one tick.
// ============================================================================
interface pps_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] running_id;
    logic        idle;
    logic [15:0] tick_time;
    logic        all_done;

    modport source (
        output valid, running_id, idle, tick_time, all_done,
        input  ready
    );
    modport sink (
        input  valid, running_id, idle, tick_time, all_done,
        output ready
    );
endinterface

// ----- design/pps_table.sv -----
// ============================================================================
// pps_table: task table storage
// One write port shared by loads and run-time decrements, one registered
// scan read port.
// ============================================================================
module pps_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       wr_en,
    input  logic [pps_pkg::SLOT_W-1:0] wr_slot,
    input  pps_pkg::entry_t            wr_data,
    input  logic [pps_pkg::SLOT_W-1:0] rd_idx,
    output pps_pkg::entry_t            rd_data,
    output logic                       rd_valid
);

    pps_pkg::entry_t                    entry_reg [pps_pkg::MAX_TASKS];
    logic [pps_pkg::MAX_TASKS-1:0]      valid_reg;
    pps_pkg::entry_t                    rd_data_reg;
    logic                               rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_slot] <= wr_data;
        end
        rd_data_reg <= entry_reg[rd_idx];
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ----- design/pps_cmp.sv -----
// ============================================================================
// pps_cmp: shared compare unit
// Checks one table entry for readiness and ranks it against the best so far.
// ============================================================================
module pps_cmp (
    input  pps_pkg::entry_t  cand,
    input  logic             cand_valid,
    input  pps_pkg::entry_t  best,
    input  logic             best_found,
    input  logic [15:0]      now,
    output pps_pkg::cmp_res_t res
);

    logic beats;

    // Priority first, then arrival, then id; a full tie keeps the lower slot.
    always_comb
    begin
        priority if (cand.priority_level != best.priority_level)
        begin
            beats = cand.priority_level < best.priority_level;
        end
        else if (cand.arrival_time != best.arrival_time)
        begin
            beats = cand.arrival_time < best.arrival_time;
        end
        else
        begin
            beats = cand.task_id < best.task_id;
        end
    end

    always_comb
    begin
        res.has_work = cand_valid && (cand.remaining != 16'd0);
        res.eligible = res.has_work && (cand.arrival_time <= now);
        res.take     = res.eligible && (!best_found || beats);
    end

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// ============================================================================
// preemptive_priority_scheduler: priority task scheduler with a task table
// Sequencer that scans the table through one shared compare unit per tick.
// ============================================================================
// Usage:
//   cmd carries requests: clear (empties the table, time back to zero),
//   load (writes one table slot, ignored beyond the table) and tick.
//   Only a tick gives a result on rsp: the id of the task that ran, the
//   idle flag, the tick time and the all-done flag.
//   Clear and load complete on acceptance. A tick is accepted, then steps
//   through every table slot in turn in the shared compare unit, then
//   retires; cmd.ready is low meanwhile.
//   The result sits in an output register, so new requests are taken while
//   it waits; a tick that finishes while the previous result is still not
//   taken holds in its retire cycle until rsp.ready frees the register.
//   Reset empties the table, zeroes time and drops any pending result.
// ============================================================================
module preemptive_priority_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    pps_cmd_if.sink   cmd,
    pps_rsp_if.source rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

    localparam logic [pps_pkg::SLOT_W-1:0] LAST_IDX = pps_pkg::SLOT_W'(pps_pkg::MAX_TASKS - 1);

    state_t                       state_reg;
    logic [pps_pkg::SLOT_W-1:0]   idx_reg;
    logic [15:0]                  time_reg;
    logic                         found_reg;
    pps_pkg::entry_t              best_reg;
    logic [pps_pkg::SLOT_W-1:0]   best_slot_reg;
    logic [1:0]                   work_cnt_reg;   // entries with work, saturates at two

    logic                         out_valid_reg;
    logic [15:0]                  out_id_reg;
    logic                         out_idle_reg;
    logic [15:0]                  out_time_reg;
    logic                         out_done_reg;

    logic                         accept;
    logic                         retire;
    logic                         load_ok;
    logic                         tbl_clear;
    logic                         tbl_wr_en;
    logic [pps_pkg::SLOT_W-1:0]   tbl_wr_slot;
    pps_pkg::entry_t              tbl_wr_data;
    logic [pps_pkg::SLOT_W-1:0]   rd_idx;
    pps_pkg::entry_t              rd_data;
    logic                         rd_valid;
    pps_pkg::cmp_res_t            cmp_res;
    logic                         work_left;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign retire    = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);
    assign load_ok   = (32'(cmd.slot) < pps_pkg::MAX_TASKS);

    // Table read is registered: fetch slot 0 while idle, then one slot ahead of the scan.
    assign rd_idx = (state_reg == ST_SCAN) ? (idx_reg + pps_pkg::SLOT_W'(1)) : '0;

    // The picked entry is counted in work_cnt; it drops out if this was its last unit.
    assign work_left = (work_cnt_reg == 2'd2) ||
                       ((work_cnt_reg == 2'd1) &&
                        !(found_reg && (best_reg.remaining == 16'd1)));

    always_comb
    begin
        tbl_clear   = accept && (cmd.kind == pps_pkg::KIND_CLEAR);
        tbl_wr_en   = 1'b0;
        tbl_wr_slot = pps_pkg::SLOT_W'(cmd.slot);
        tbl_wr_data = '{task_id:        cmd.task_id,
                        arrival_time:   cmd.arrival_time,
                        remaining:      cmd.run_time,
                        priority_level: cmd.priority_level};
        if (accept && (cmd.kind == pps_pkg::KIND_LOAD) && load_ok)
        begin
            tbl_wr_en = 1'b1;
        end
        else if (retire && found_reg)
        begin
            tbl_wr_en             = 1'b1;
            tbl_wr_slot           = best_slot_reg;
            tbl_wr_data           = best_reg;
            tbl_wr_data.remaining = best_reg.remaining - 16'd1;
        end
    end

    pps_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (tbl_clear),
        .wr_en    (tbl_wr_en),
        .wr_slot  (tbl_wr_slot),
        .wr_data  (tbl_wr_data),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    pps_cmp u_cmp (
        .cand       (rd_data),
        .cand_valid (rd_valid),
        .best       (best_reg),
        .best_found (found_reg),
        .now        (time_reg),
        .res        (cmp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            time_reg      <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_slot_reg <= '0;
            work_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_idle_reg  <= 1'b0;
            out_time_reg  <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.kind == pps_pkg::KIND_CLEAR)
                        begin
                            time_reg <= '0;
                        end
                        else if (cmd.kind == pps_pkg::KIND_TICK)
                        begin
                            idx_reg      <= '0;
                            found_reg    <= 1'b0;
                            work_cnt_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (cmp_res.take)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= rd_data;
                        best_slot_reg <= idx_reg;
                    end
                    if (cmp_res.has_work && (work_cnt_reg != 2'd2))
                    begin
                        work_cnt_reg <= work_cnt_reg + 2'd1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + pps_pkg::SLOT_W'(1);
                    end
                end
                ST_FIN:
                begin
                    if (retire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= found_reg ? best_reg.task_id : 16'd0;
                        out_idle_reg  <= !found_reg;
                        out_time_reg  <= time_reg;
                        out_done_reg  <= !work_left;
                        if (time_reg != pps_pkg::TIME_MAX)
                        begin
                            time_reg <= time_reg + 16'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.running_id = out_id_reg;
    assign rsp.idle       = out_idle_reg;
    assign rsp.tick_time  = out_time_reg;
    assign rsp.all_done   = out_done_reg;

endmodule
